// ===== rtl/pipelined_memory_stage_macros.svh =====
// Assertion macros shared by the memory stage modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef PIPELINED_MEMORY_STAGE_MACROS_SVH
`define PIPELINED_MEMORY_STAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pms_pkg.sv =====
// Shared constants, codes and types of the pipelined memory stage.
// Depends on nothing; used by pms_mem_ctrl and pipelined_memory_stage.
`timescale 1ns / 1ps

package pms_pkg;

    // Byte store geometry: four byte lanes, one word row across them.
    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int LANES     = 4;
    localparam int ROWS      = MEM_BYTES / LANES;
    localparam int ROW_W     = ADDR_W - 2;

    // Item kinds carried on tuser.
    localparam logic [1:0] KIND_STEP  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_AOK = 2'd0;
    localparam logic [1:0] STAT_HLT = 2'd1;
    localparam logic [1:0] STAT_ADR = 2'd2;
    localparam logic [1:0] STAT_INS = 2'd3;

    // Instruction codes that touch memory.
    localparam logic [3:0] I_REG_TO_MEM = 4'd4;
    localparam logic [3:0] I_MEM_TO_REG = 4'd5;
    localparam logic [3:0] I_CALL       = 4'd8;
    localparam logic [3:0] I_RET        = 4'd9;
    localparam logic [3:0] I_PUSHL      = 4'd10;
    localparam logic [3:0] I_POPL       = 4'd11;

    // Request to one byte lane memory.
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [ROW_W-1:0] raddr;
    } lane_req_t;

    // What the controller hands to the pipeline for an accepted step.
    typedef struct packed {
        logic [1:0] stat;
        logic       rd_hit;
        logic       rd_miss;
        logic [1:0] off;
    } step_info_t;

endpackage

// ===== rtl/pms_lane_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instantiated once per byte lane.
`timescale 1ns / 1ps

module pms_lane_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data only moves on a read, so it holds while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pms_mem_ctrl.sv =====
// Access controller: decodes an accepted item, keeps the write-enable flag,
// runs the clearing sweep after reset and drives the four lane memories.
// Depends on pms_pkg and pipelined_memory_stage_macros.svh.
`timescale 1ns / 1ps
`include "pipelined_memory_stage_macros.svh"

module pms_mem_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  acc,
    input  logic [1:0]            kind,
    input  logic [1:0]            in_stat,
    input  logic [3:0]            in_icode,
    input  logic [31:0]           in_val_e,
    input  logic [31:0]           in_val_a,
    input  logic [11:0]           load_addr,
    input  logic [7:0]            load_byte,
    output logic                  busy,
    output pms_pkg::lane_req_t    lane_req [pms_pkg::LANES],
    output pms_pkg::step_info_t   info
);

    logic                      writes_allowed_reg;
    logic                      writes_allowed_next;
    logic                      clr_active_reg;
    logic                      clr_active_next;
    logic [pms_pkg::ROW_W-1:0] clr_row_reg;
    logic [pms_pkg::ROW_W-1:0] clr_row_next;

    logic                      step;
    logic                      wa_eff;
    logic                      is_rd;
    logic                      is_wr;
    logic [31:0]               addr;
    logic                      addr_ok;
    logic                      err;
    logic                      do_store;
    logic                      do_read;
    logic                      do_load;
    logic [31:0]               load_addr_ext;
    logic [pms_pkg::ROW_W-1:0] row_base;
    logic [1:0]                off;

    assign busy = clr_active_reg;
    assign step = acc && (kind == pms_pkg::KIND_STEP);

    always_comb
    begin
        // A faulting incoming status blocks this item's write as well.
        wa_eff = writes_allowed_reg && (in_stat == pms_pkg::STAT_AOK);
        is_rd  = (in_icode == pms_pkg::I_MEM_TO_REG) || (in_icode == pms_pkg::I_RET) ||
                 (in_icode == pms_pkg::I_POPL);
        is_wr  = (in_icode == pms_pkg::I_REG_TO_MEM) || (in_icode == pms_pkg::I_CALL) ||
                 (in_icode == pms_pkg::I_PUSHL);
        if ((in_icode == pms_pkg::I_RET) || (in_icode == pms_pkg::I_POPL))
        begin
            addr = in_val_a;
        end
        else if (is_rd || is_wr)
        begin
            addr = in_val_e;
        end
        else
        begin
            addr = 32'd0;
        end
        addr_ok  = addr < 32'(pms_pkg::MEM_BYTES - 3);
        err      = (is_rd || (is_wr && wa_eff)) && !addr_ok;
        do_store = step && is_wr && wa_eff && addr_ok;
        do_read  = step && is_rd && addr_ok;

        load_addr_ext = 32'(load_addr);
        do_load = acc && (kind == pms_pkg::KIND_LOAD) &&
                  (load_addr_ext < 32'(pms_pkg::MEM_BYTES));

        row_base = addr[pms_pkg::ADDR_W-1:2];
        off      = addr[1:0];

        info.stat    = err ? pms_pkg::STAT_ADR : in_stat;
        info.rd_hit  = is_rd && addr_ok;
        info.rd_miss = is_rd && !addr_ok;
        info.off     = off;
    end

    // A word at byte offset off spills into the next row for lanes below off.
    always_comb
    begin
        for (int b = 0; b < pms_pkg::LANES; b++)
        begin
            logic [1:0]                lane_id;
            logic [1:0]                sel;
            logic [pms_pkg::ROW_W-1:0] row;
            lane_id = 2'(b);
            sel     = lane_id - off;
            row     = row_base + pms_pkg::ROW_W'(lane_id < off);

            lane_req[b].re    = do_read;
            lane_req[b].raddr = row;
            lane_req[b].we    = 1'b0;
            lane_req[b].waddr = row;
            lane_req[b].wdata = in_val_a[{sel, 3'b000} +: 8];
            if (clr_active_reg)
            begin
                lane_req[b].we    = 1'b1;
                lane_req[b].waddr = clr_row_reg;
                lane_req[b].wdata = 8'd0;
            end
            else if (do_store)
            begin
                lane_req[b].we = 1'b1;
            end
            else if (do_load && (load_addr_ext[1:0] == lane_id))
            begin
                lane_req[b].we    = 1'b1;
                lane_req[b].waddr = load_addr_ext[pms_pkg::ADDR_W-1:2];
                lane_req[b].wdata = load_byte;
            end
        end
    end

    always_comb
    begin
        writes_allowed_next = writes_allowed_reg;
        if (acc)
        begin
            case (kind)
                pms_pkg::KIND_STEP:  writes_allowed_next = wa_eff && !err;
                pms_pkg::KIND_CLEAR: writes_allowed_next = 1'b1;
                default:             writes_allowed_next = writes_allowed_reg;
            endcase
        end

        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg)
        begin
            clr_row_next    = clr_row_reg + pms_pkg::ROW_W'(1);
            clr_active_next = (clr_row_reg != pms_pkg::ROW_W'(pms_pkg::ROWS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writes_allowed_reg <= 1'b1;
            clr_active_reg     <= 1'b1;
            clr_row_reg        <= '0;
        end
        else
        begin
            writes_allowed_reg <= writes_allowed_next;
            clr_active_reg     <= clr_active_next;
            clr_row_reg        <= clr_row_next;
        end
    end

    `PMS_ASSERT_IMP(a_no_accept_in_sweep, clk, rst_n, clr_active_reg, !acc,
        "item accepted during the clearing sweep")
    `PMS_ASSERT_NXT(a_fault_blocks_writes, clk, rst_n,
        step && ((in_stat != pms_pkg::STAT_AOK) || err), !writes_allowed_reg,
        "writes still enabled after a faulting step")
    `PMS_ASSERT_NXT(a_clear_rearms, clk, rst_n, acc && (kind == pms_pkg::KIND_CLEAR),
        writes_allowed_reg, "clear item did not re-arm writes")

endmodule

// ===== rtl/pipelined_memory_stage.sv =====
// Throughput: one item per cycle while the byte store is not being swept and m_axis
// does not stall. A step is read from the lane memories into the s1 register, then
// moves into the output register; both registers hold while m_axis stalls.
// Load and clear items produce no result.
// Reset: rst_n is asynchronous, active low. After reset the byte store is swept
// to zero one word row per cycle over all MEM_BYTES/4 (1024) rows, s_axis_tready low.
`timescale 1ns / 1ps
`include "pipelined_memory_stage_macros.svh"

module pipelined_memory_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // in_stat[1:0], in_icode[5:2], in_cnd[6], in_val_e[38:7], in_val_a[70:39],
    // in_dst_e[74:71], in_dst_m[78:75], wb_stat[80:79], load_addr[92:81],
    // load_byte[100:93], zero fill[103:101]
    input  logic [103:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_stat[1:0], out_icode[5:2], out_cnd[6], out_val_e[38:7],
    // out_val_a[70:39], out_val_m[102:71], out_dst_e[106:103],
    // out_dst_m[110:107], wb_update[111]
    output logic [111:0] m_axis_tdata
);

    typedef struct packed {
        logic [3:0]          icode;
        logic                cnd;
        logic [31:0]         val_e;
        logic [31:0]         val_a;
        logic [3:0]          dst_e;
        logic [3:0]          dst_m;
        logic [1:0]          wb_stat;
        pms_pkg::step_info_t info;
    } s1_t;

    pms_pkg::lane_req_t  lane_req [pms_pkg::LANES];
    pms_pkg::step_info_t info;
    logic [7:0]          lane_rdata [pms_pkg::LANES];
    logic                busy;

    logic                acc;
    logic                step_acc;
    logic                out_free;
    logic                s1_adv;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    s1_t                 s1_reg;
    s1_t                 s1_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [111:0]        out_data_reg;
    logic [111:0]        out_data_next;
    logic [31:0]         word;
    logic [31:0]         val_m;

    pms_mem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .kind      (s_axis_tuser),
        .in_stat   (s_axis_tdata[1:0]),
        .in_icode  (s_axis_tdata[5:2]),
        .in_val_e  (s_axis_tdata[38:7]),
        .in_val_a  (s_axis_tdata[70:39]),
        .load_addr (s_axis_tdata[92:81]),
        .load_byte (s_axis_tdata[100:93]),
        .busy      (busy),
        .lane_req  (lane_req),
        .info      (info)
    );

    for (genvar g = 0; g < pms_pkg::LANES; g++)
    begin : g_lane
        pms_lane_ram #(
            .DEPTH (pms_pkg::ROWS),
            .WIDTH (8)
        ) u_ram (
            .clk   (clk),
            .we    (lane_req[g].we),
            .waddr (lane_req[g].waddr),
            .wdata (lane_req[g].wdata),
            .re    (lane_req[g].re),
            .raddr (lane_req[g].raddr),
            .rdata (lane_rdata[g])
        );
    end

    // The output register frees s1 whenever it is empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !busy && (!s1_valid_reg || out_free);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign step_acc      = acc && (s_axis_tuser == pms_pkg::KIND_STEP);

    always_comb
    begin
        s1_next.icode   = s_axis_tdata[5:2];
        s1_next.cnd     = s_axis_tdata[6];
        s1_next.val_e   = s_axis_tdata[38:7];
        s1_next.val_a   = s_axis_tdata[70:39];
        s1_next.dst_e   = s_axis_tdata[74:71];
        s1_next.dst_m   = s_axis_tdata[78:75];
        s1_next.wb_stat = s_axis_tdata[80:79];
        s1_next.info    = info;
        s1_valid_next   = step_acc || (s1_valid_reg && !out_free);
    end

    // Byte i of the word sits in lane (off + i) mod 4.
    always_comb
    begin
        for (int i = 0; i < pms_pkg::LANES; i++)
        begin
            logic [1:0] lane;
            lane = s1_reg.info.off + 2'(i);
            word[8*i +: 8] = lane_rdata[lane];
        end
        if (s1_reg.info.rd_hit)
        begin
            val_m = word;
        end
        else if (s1_reg.info.rd_miss)
        begin
            val_m = 32'd0;
        end
        else
        begin
            val_m = s1_reg.val_a;
        end
        out_data_next = {(s1_reg.wb_stat == pms_pkg::STAT_AOK), s1_reg.dst_m,
                         s1_reg.dst_e, val_m, s1_reg.val_a, s1_reg.val_e,
                         s1_reg.cnd, s1_reg.icode, s1_reg.info.stat};
        out_valid_next = s1_adv || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_acc)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `PMS_ASSERT_NXT(a_step_enters_s1, clk, rst_n, step_acc, s1_valid_reg,
        "accepted step did not reach the read stage")
    `PMS_ASSERT_NXT(a_s1_holds_on_stall, clk, rst_n, s1_valid_reg && !out_free,
        s1_valid_reg, "read stage lost an item while the output stalled")
    `PMS_ASSERT_NXT(a_out_holds_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while the output stalled")

endmodule
